### hdl/multiplexed_servo_pulse_sequencer_top_macros.svh
// assertion macros for the servo sequencer port checker
`ifndef MULTIPLEXED_SERVO_PULSE_SEQUENCER_TOP_MACROS_SVH
`define MULTIPLEXED_SERVO_PULSE_SEQUENCER_TOP_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define MSPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define MSPS_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### hdl/msps_pkg.sv
// types and constants for the servo pulse sequencer
package msps_pkg;

  // number of servo channels, fixed by the pin and channel field widths
  localparam int unsigned Channels = 2;

  // field widths
  localparam int unsigned LeadW   = 8;
  localparam int unsigned WindowW = 10;
  localparam int unsigned GapW    = 12;
  localparam int unsigned CountW  = 12;
  localparam int unsigned WidthW  = 8;
  localparam int unsigned PinsW   = 2;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  // register reset values
  localparam logic [LeadW-1:0]   LeadReset   = 8'd61;
  localparam logic [WindowW-1:0] WindowReset = 10'd248;
  localparam logic [GapW-1:0]    GapReset    = 12'd1750;

  // register indexes (word address)
  localparam logic [1:0] RegLead   = 2'd0;
  localparam logic [1:0] RegWindow = 2'd1;
  localparam logic [1:0] RegGap    = 2'd2;

  // item kinds
  localparam logic KindTick  = 1'b0;
  localparam logic KindWidth = 1'b1;

  // per-channel phase
  typedef enum logic [2:0] {
    PH_LEAD   = 3'b001,
    PH_WINDOW = 3'b010,
    PH_GAP    = 3'b100
  } phase_e;

endpackage

### hdl/multiplexed_servo_pulse_sequencer_top.sv
// servo pulse sequencer: phase counter, width store, result register, config port
// Latency: the result of an item is registered and shown in the cycle after it is accepted.
// Throughput: one item per cycle; the next item is taken while the result register
// is being read, so the only stall comes from the output channel's ready.
// Reset (asynchronous, active low): lead phase of channel 0, count and widths zero,
// registers at their reset values; items are accepted right after reset.
module multiplexed_servo_pulse_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic        channel_i,
  input  logic [7:0]  width_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  pins_o,
  output logic        active_channel_o,
  output logic        frame_start_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import msps_pkg::*;

  localparam int unsigned ChW = (Channels > 1) ? $clog2(Channels) : 1;

  // configuration registers
  logic [LeadW-1:0]   lead_q;
  logic [WindowW-1:0] window_q;
  logic [GapW-1:0]    gap_q;
  logic               cfg_wr;

  // sequencer state
  phase_e             phase_q, phase_d;
  logic [ChW-1:0]     ch_q, ch_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [WidthW-1:0]  latched_q, latched_d;
  logic [WidthW-1:0]  widths_q [Channels];

  // handshake and result
  logic               accept;
  logic               is_tick;
  logic               out_valid_q;
  logic [PinsW-1:0]   pins_q, pins_d;
  logic               active_q;
  logic               fs_q, fs_d;
  logic               pin_on;
  logic [CountW:0]    count_inc;
  logic [CountW:0]    limit;
  logic               done;

  // apb access
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      RegLead:   prdata = DataW'(lead_q);
      RegWindow: prdata = DataW'(window_q);
      RegGap:    prdata = DataW'(gap_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q   <= LeadReset;
      window_q <= WindowReset;
      gap_q    <= GapReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegLead:   lead_q   <= pwdata[LeadW-1:0];
        RegWindow: window_q <= pwdata[WindowW-1:0];
        RegGap:    gap_q    <= pwdata[GapW-1:0];
        default:   ;
      endcase
    end
  end

  // output register frees up when empty or being read
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_tick    = (kind_i == KindTick);

  // pins during the current tick
  always_comb begin
    pin_on = 1'b0;
    case (phase_q)
      PH_LEAD:   pin_on = 1'b1;
      PH_WINDOW: pin_on = (latched_q >= WidthW'(2)) &&
                          (count_q <= CountW'(latched_q));
      default:   pin_on = 1'b0;
    endcase
    pins_d = '0;
    for (int k = 0; k < PinsW; k++) begin
      if (k < Channels) begin
        pins_d[k] = pin_on && (ch_q == ChW'(k));
      end
    end
    fs_d = is_tick && (phase_q == PH_LEAD) && (count_q == '0) && (ch_q == '0);
  end

  // limit of the current phase and end-of-phase test
  always_comb begin
    case (phase_q)
      PH_LEAD:   limit = (CountW+1)'(lead_q);
      PH_WINDOW: limit = (CountW+1)'(window_q);
      PH_GAP:    limit = (CountW+1)'(gap_q);
      default:   limit = '0;
    endcase
    count_inc = {1'b0, count_q} + (CountW+1)'(1);
    done      = (count_inc >= limit);
  end

  // next state for one tick
  always_comb begin
    phase_d   = phase_q;
    ch_d      = ch_q;
    count_d   = count_q;
    latched_d = latched_q;
    case (phase_q)
      PH_LEAD: begin
        if (done) begin
          phase_d   = PH_WINDOW;
          count_d   = '0;
          latched_d = widths_q[ch_q];
        end else begin
          count_d = count_inc[CountW-1:0];
        end
      end
      PH_WINDOW: begin
        if (done) begin
          count_d = '0;
          if (ch_q == ChW'(Channels - 1)) begin
            ch_d    = '0;
            phase_d = PH_GAP;
          end else begin
            ch_d    = ch_q + ChW'(1);
            phase_d = PH_LEAD;
          end
        end else begin
          count_d = count_inc[CountW-1:0];
        end
      end
      PH_GAP: begin
        if (done) begin
          count_d = '0;
          ch_d    = '0;
          phase_d = PH_LEAD;
        end else begin
          count_d = count_inc[CountW-1:0];
        end
      end
      default: begin
        phase_d = PH_LEAD;
        count_d = '0;
      end
    endcase
  end

  // state registers advance on tick items only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEAD;
      ch_q      <= '0;
      count_q   <= '0;
      latched_q <= '0;
    end else if (accept && is_tick) begin
      phase_q   <= phase_d;
      ch_q      <= ch_d;
      count_q   <= count_d;
      latched_q <= latched_d;
    end
  end

  // width store, written by set-width items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        widths_q[i] <= '0;
      end
    end else if (accept && (kind_i == KindWidth)) begin
      for (int i = 0; i < Channels; i++) begin
        if (ChW'(channel_i) == ChW'(i)) begin
          widths_q[i] <= width_i;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pins_q   <= pins_d;
      active_q <= ch_q[0];
      fs_q     <= fs_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pins_o           = pins_q;
  assign active_channel_o = active_q;
  assign frame_start_o    = fs_q;

endmodule

### hdl/msps_checker.sv
// port-level checks for the servo pulse sequencer, bound to the top level
`include "multiplexed_servo_pulse_sequencer_top_macros.svh"

module msps_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] pins_o,
  input logic       active_channel_o,
  input logic       frame_start_o
);

  logic pin_elsewhere;
  logic frame_lead;
  logic out_stalled;

  assign pin_elsewhere = out_valid_o && (pins_o != 2'b00) && !pins_o[active_channel_o];
  assign frame_lead    = (pins_o == 2'b01) && !active_channel_o;
  assign out_stalled   = out_valid_o && !out_ready_i;

  // only one servo pin may be driven at a time
  `MSPS_ASSERT(a_pins_onehot, out_valid_o |-> $onehot0(pins_o), "more than one pin high")

  // a driven pin belongs to the channel being served
  `MSPS_NEVER(a_pin_channel, pin_elsewhere, "pin high for a channel not being served")

  // a frame opens with channel 0 in its lead, pin high
  `MSPS_ASSERT(a_frame_start, (out_valid_o && frame_start_o) |-> frame_lead, "bad frame start")

  // a stalled result item holds its payload
  `MSPS_ASSERT(a_out_hold, out_stalled |=> (out_valid_o && $stable({pins_o, active_channel_o, frame_start_o})), "stalled result changed")

endmodule

bind multiplexed_servo_pulse_sequencer_top msps_sva u_msps_checker (.*);

### verif/msps_checker.sv
// servo sequencer checker: watches both item channels and the config port, predicts and compares
module msps_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        kind_i,
  input  logic        channel_i,
  input  logic [7:0]  width_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  pins_i,
  input  logic        active_channel_i,
  input  logic        frame_start_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          mismatches_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import msps_pkg::*;

  typedef struct packed {
    logic [PinsW-1:0] pins;
    logic             active_channel;
    logic             frame_start;
  } pulse_result_t;

  // timing registers as last written
  logic [LeadW-1:0]   lead_ticks;
  logic [WindowW-1:0] window_ticks;
  logic [GapW-1:0]    gap_ticks;

  // sequencer state
  phase_e             phase;
  logic               chan_idx;
  logic [CountW-1:0]  phase_cnt;
  logic [WidthW-1:0]  held_width;
  logic [WidthW-1:0]  chan_width [2];

  pulse_result_t expected_pulses [$];
  int            mismatch_cnt = 0;
  int            result_no = 0;

  assign mismatches_o = mismatch_cnt;

  // one line per mismatch, counted
  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatch_cnt++;
  endtask

  // a zero span behaves like one tick; the count already includes this tick
  function automatic logic span_ends(logic [GapW-1:0] span);
    return ({1'b0, phase_cnt} + 13'd1) >= {1'b0, span};
  endfunction

  // result of one item, then advance the sequencer on a tick
  function automatic pulse_result_t step_sequencer(logic kind, logic chan,
                                                   logic [WidthW-1:0] width);
    pulse_result_t res;
    logic [PinsW-1:0] own_pin;
    own_pin = 2'b01 << chan_idx;
    res.active_channel = chan_idx;
    res.frame_start = 1'b0;
    res.pins = '0;
    if (phase == PH_LEAD) begin
      res.pins = own_pin;
    end else if (phase == PH_WINDOW && held_width >= 2 && phase_cnt <= held_width) begin
      res.pins = own_pin;
    end
    if (kind == KindWidth) begin
      chan_width[chan] = width;
    end else begin
      res.frame_start = (phase == PH_LEAD && phase_cnt == 0 && chan_idx == 1'b0);
      case (phase)
        PH_LEAD: begin
          if (span_ends(lead_ticks)) begin
            phase = PH_WINDOW;
            phase_cnt = '0;
            held_width = chan_width[chan_idx];
          end else begin
            phase_cnt++;
          end
        end
        PH_WINDOW: begin
          if (span_ends(window_ticks)) begin
            phase_cnt = '0;
            // after the last channel the frame closes with the gap
            if (chan_idx == 1'b1) begin
              chan_idx = 1'b0;
              phase = PH_GAP;
            end else begin
              chan_idx = 1'b1;
              phase = PH_LEAD;
            end
          end else begin
            phase_cnt++;
          end
        end
        PH_GAP: begin
          if (span_ends(gap_ticks)) begin
            phase_cnt = '0;
            chan_idx = 1'b0;
            phase = PH_LEAD;
          end else begin
            phase_cnt++;
          end
        end
        default: begin
          phase = PH_LEAD;
          phase_cnt = '0;
        end
      endcase
    end
    return res;
  endfunction

  // register writes, result comparison, then prediction of the newly taken item
  always @(posedge clk_i or negedge rst_ni) begin
    pulse_result_t want;
    if (!rst_ni) begin
      lead_ticks = LeadReset;
      window_ticks = WindowReset;
      gap_ticks = GapReset;
      phase = PH_LEAD;
      chan_idx = 1'b0;
      phase_cnt = '0;
      held_width = '0;
      chan_width[0] = '0;
      chan_width[1] = '0;
      expected_pulses.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          RegLead:   lead_ticks = pwdata_i[LeadW-1:0];
          RegWindow: window_ticks = pwdata_i[WindowW-1:0];
          RegGap:    gap_ticks = pwdata_i[GapW-1:0];
          default:   ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pulses.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no item waiting (pins %b)",
                                    result_no, pins_i));
        end else begin
          want = expected_pulses.pop_front();
          if (pins_i !== want.pins)
            report_mismatch($sformatf("result %0d pins %b, expected %b",
                                      result_no, pins_i, want.pins));
          if (active_channel_i !== want.active_channel)
            report_mismatch($sformatf("result %0d active_channel %b, expected %b",
                                      result_no, active_channel_i, want.active_channel));
          if (frame_start_i !== want.frame_start)
            report_mismatch($sformatf("result %0d frame_start %b, expected %b",
                                      result_no, frame_start_i, want.frame_start));
        end
        result_no++;
      end
      if (in_valid_i && in_ready_i) begin
        expected_pulses.push_back(step_sequencer(kind_i, channel_i, width_i));
      end
      pending_o <= expected_pulses.size();
    end
  end

endmodule

### verif/testbench.sv
// testbench top for the servo sequencer: clock, reset, stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import msps_pkg::*;

  localparam int         WatchdogLimit = 1000;
  localparam int         PhaseItems    = 152;
  localparam int         RandomPhases  = 10;
  // address beyond the three timing registers
  localparam logic [1:0] RegSpare      = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = KindTick;
  logic        chan = 1'b0;
  logic [7:0]  width = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  pins;
  logic        active_channel;
  logic        frame_start;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          pending;
  int          stall_left = 0;
  int          idle_cycles = 0;
  bit          send_gaps = 1'b1;
  bit          recv_stalls = 1'b1;
  logic [9:0]  window_set = WindowReset;

  always #2ns clk_i = ~clk_i;

  multiplexed_servo_pulse_sequencer_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .kind_i           (kind),
    .channel_i        (chan),
    .width_i          (width),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .pins_o           (pins),
    .active_channel_o (active_channel),
    .frame_start_o    (frame_start),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  msps_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .kind_i           (kind),
    .channel_i        (chan),
    .width_i          (width),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .pins_i           (pins),
    .active_channel_i (active_channel),
    .frame_start_i    (frame_start),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  // result side: optional random stall after each taken result
  always @(posedge clk_i) begin
    int unsigned hold;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        hold = recv_stalls ? $urandom_range(0, 3) : 0;
        stall_left <= hold;
        out_ready <= (hold == 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= (stall_left == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on any port
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // offer one item after an optional random pause and hold it until taken
  task automatic send_item(logic k, logic c, logic [7:0] w);
    int unsigned pause;
    pause = send_gaps ? $urandom_range(0, 3) : 0;
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind <= k;
    chan <= c;
    width <= w;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // stop offering items and wait until every result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // setup then access phase, then idle with psel low
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timing(logic [7:0] lead, logic [9:0] window, logic [11:0] gap);
    wait_drained();
    write_reg(RegLead, 32'(lead));
    write_reg(RegWindow, 32'(window));
    write_reg(RegGap, 32'(gap));
    window_set = window;
  endtask

  initial begin
    logic       k;
    logic [7:0] w;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timing: width writes around the frame start tick
    send_item(KindWidth, 1'b0, 8'd255);
    send_item(KindTick, 1'b1, 8'hAA);
    send_item(KindWidth, 1'b1, 8'd1);

    // zero lead and gap act as one tick; spare address must be ignored
    set_timing(8'd0, 10'd4, 12'd0);
    write_reg(RegSpare, 32'hFFFF_FFFF);

    // short pulse on channel 0, pulse cut by the window on channel 1
    send_item(KindWidth, 1'b0, 8'd2);
    send_item(KindWidth, 1'b1, 8'd255);
    repeat (11) send_item(KindTick, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    // widths of zero and one give no variable pulse; write during a window
    send_item(KindWidth, 1'b0, 8'd1);
    send_item(KindWidth, 1'b1, 8'd0);
    send_item(KindTick, 1'b0, 8'h55);
    send_item(KindTick, 1'b1, 8'h00);
    send_item(KindWidth, 1'b0, 8'd128);
    repeat (4) send_item(KindTick, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

    // random phases over several timing settings, extremes among them
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        2:       set_timing(8'd255, 10'd1023, 12'd4095);
        4:       set_timing(8'd1, 10'd1, 12'd1);
        6:       set_timing(8'd0, 10'd0, 12'd0);
        8:       set_timing(8'($urandom_range(1, 40)), 10'($urandom_range(1, 300)),
                            12'($urandom_range(1, 600)));
        default: set_timing(8'($urandom_range(1, 6)), 10'($urandom_range(1, 12)),
                            12'($urandom_range(1, 16)));
      endcase
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_stalls = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PhaseItems; n++) begin
        k = ($urandom_range(0, 9) < 2) ? KindWidth : KindTick;
        // widths cluster around the window length so pulses end on both sides of it
        case ($urandom_range(0, 4))
          0:       w = 8'($urandom_range(0, 3));
          1, 2:    w = 8'($urandom_range(0, (window_set > 250) ? 255 : window_set + 4));
          default: w = 8'($urandom_range(0, 255));
        endcase
        send_item(k, 1'($urandom_range(0, 1)), w);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
